[hw/rtl/bmq_pkg.sv]
// shared types and constants of the bitmap index and query block
`timescale 1ns / 1ps
package bmq_pkg;

   localparam int MAX_KEYWORDS_DEF = 1024;
   localparam int MAX_OBJECTS_DEF  = 4096;
   localparam int KW_W             = 10;
   localparam int CNT_W            = 13;
   localparam int WIDX_W           = 6;
   localparam int MASK_W           = 64;

   typedef enum logic [1:0] {
      KIND_CLEAR   = 2'd0,
      KIND_KEYWORD = 2'd1,
      KIND_CLOSE   = 2'd2,
      KIND_QUERY   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [KW_W-1:0]   keyword;
      logic              kw_ok;
      logic              last;
   } item_type;

   typedef struct packed {
      logic clearing;
   } stat_type;

endpackage

[hw/rtl/bmq_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
module bmq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/bmq_front.sv]
// front end: accepts and classifies items into a two-entry queue
`timescale 1ns / 1ps
module bmq_front #(
   parameter int MAX_KEYWORDS = bmq_pkg::MAX_KEYWORDS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_kind,
   input  logic [bmq_pkg::KW_W-1:0]  req_keyword,
   input  logic                      req_last,
   input  bmq_pkg::stat_type         stat,
   output logic                      item_valid,
   output bmq_pkg::item_type         item,
   input  logic                      item_pop
);

   bmq_pkg::item_type q_ff [2];
   bmq_pkg::item_type cls;
   logic              wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;

   // classify the incoming item
   always_comb begin
      cls.kind    = bmq_pkg::kind_type'(req_kind);
      cls.keyword = req_keyword;
      cls.kw_ok   = (32'(req_keyword) < MAX_KEYWORDS);
      cls.last    = req_last;
   end

   assign busy       = (cnt_ff == 2'd2) || stat.clearing;
   assign push       = start && !busy;
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rp_ff];

   // queue pointers
   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = item_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

endmodule

[hw/rtl/bmq_back.sv]
// back end: store updates, query passes and result emission
`timescale 1ns / 1ps
module bmq_back #(
   parameter int MAX_KEYWORDS = bmq_pkg::MAX_KEYWORDS_DEF,
   parameter int MAX_OBJECTS  = bmq_pkg::MAX_OBJECTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   input  bmq_pkg::item_type           item,
   output logic                        item_pop,
   output bmq_pkg::stat_type           stat,
   output logic                        rsp_valid,
   output logic [bmq_pkg::WIDX_W-1:0]  rsp_word_index,
   output logic [bmq_pkg::MASK_W-1:0]  rsp_hit_mask,
   output logic                        rsp_empty_res,
   output logic                        rsp_last_result
);

   localparam int WORDS = (MAX_OBJECTS + 63) / 64;
   localparam int DEPTH = MAX_KEYWORDS * WORDS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int WCW   = $clog2(WORDS + 1);
   localparam int CW    = bmq_pkg::CNT_W;
   localparam int MW    = bmq_pkg::MASK_W;

   typedef enum logic [5:0] {
      ST_CLR    = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_INS_RD = 6'b000100,
      ST_INS_WR = 6'b001000,
      ST_QRUN   = 6'b010000,
      ST_QEND   = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   bmq_pkg::item_type cur_ff, cur_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              open_ff, open_in, failed_ff, failed_in, first_ff, first_in;
   logic [WCW-1:0]    iss_ff, iss_in, rdw_ff, rdw_in;
   logic              rdv_ff, rdv_in;
   logic [AW-1:0]     iaddr_ff, iaddr_in;
   logic              pv_ff, pv_in;
   logic [WCW-1:0]    pw_ff, pw_in;
   logic [MW-1:0]     pm_ff, pm_in;
   logic              ov_ff, ov_in, oe_ff, oe_in, ol_ff, ol_in;
   logic [bmq_pkg::WIDX_W-1:0] ow_ff, ow_in;
   logic [MW-1:0]     om_ff, om_in;

   logic              bm_we, hw_we;
   logic [AW-1:0]     bm_waddr, bm_raddr, bm_base;
   logic [MW-1:0]     bm_wdata, bm_rdata, hw_wdata, hw_rdata, newv, hit;
   logic [HAW-1:0]    hw_waddr, hw_raddr;

   // mask of closed objects inside one word
   function automatic logic [63:0] vmask(input logic [CW-1:0] c, input logic [WCW-1:0] w);
      logic [6:0] cw;
      logic [6:0] wi;
      cw = c[CW-1:6];
      wi = 7'(w);
      if (wi < cw) begin
         return '1;
      end else if (wi == cw) begin
         return (64'd1 << c[5:0]) - 64'd1;
      end else begin
         return '0;
      end
   endfunction

   bmq_ram #(.WIDTH(MW), .DEPTH(DEPTH), .AW(AW)) u_bitmaps (
      .clock(clock), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
      .raddr(bm_raddr), .rdata(bm_rdata)
   );

   bmq_ram #(.WIDTH(MW), .DEPTH(WORDS), .AW(HAW)) u_hits (
      .clock(clock), .we(hw_we), .waddr(hw_waddr), .wdata(hw_wdata),
      .raddr(hw_raddr), .rdata(hw_rdata)
   );

   assign bm_base = AW'(cur_ff.keyword) * AW'(WORDS);
   assign newv    = first_ff ? bm_rdata : (bm_rdata & hw_rdata);
   assign hit     = newv & vmask(count_ff, rdw_ff);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      clr_in    = clr_ff;
      count_in  = count_ff;
      open_in   = open_ff;
      failed_in = failed_ff;
      first_in  = first_ff;
      iss_in    = iss_ff;
      rdw_in    = rdw_ff;
      rdv_in    = 1'b0;
      iaddr_in  = iaddr_ff;
      pv_in     = pv_ff;
      pw_in     = pw_ff;
      pm_in     = pm_ff;
      ov_in     = 1'b0;
      oe_in     = 1'b0;
      ol_in     = 1'b0;
      ow_in     = '0;
      om_in     = '0;
      item_pop  = 1'b0;
      bm_we     = 1'b0;
      bm_waddr  = clr_ff;
      bm_wdata  = '0;
      bm_raddr  = bm_base + AW'(count_ff[CW-1:6]);
      hw_we     = 1'b0;
      hw_waddr  = HAW'(rdw_ff);
      hw_wdata  = newv;
      hw_raddr  = HAW'(iss_ff);
      unique case (state_ff)
         ST_CLR: begin
            bm_we  = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               cur_in   = item;
               case (item.kind)
                  bmq_pkg::KIND_CLEAR: begin
                     state_in  = ST_CLR;
                     clr_in    = '0;
                     count_in  = '0;
                     open_in   = 1'b0;
                     failed_in = 1'b0;
                  end
                  bmq_pkg::KIND_KEYWORD: begin
                     if (count_ff < CW'(MAX_OBJECTS) && item.kw_ok) begin
                        state_in = ST_INS_RD;
                     end
                  end
                  bmq_pkg::KIND_CLOSE: begin
                     if (count_ff < CW'(MAX_OBJECTS)) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  default: begin
                     open_in = 1'b1;
                     pv_in   = 1'b0;
                     if (!item.kw_ok) begin
                        failed_in = 1'b1;
                        if (item.last) begin
                           state_in = ST_QEND;
                        end
                     end else begin
                        first_in = !open_ff;
                        if (!open_ff) begin
                           failed_in = 1'b0;
                        end
                        iss_in   = '0;
                        state_in = ST_QRUN;
                     end
                  end
               endcase
            end
         end
         ST_INS_RD: begin
            iaddr_in = bm_raddr;
            state_in = ST_INS_WR;
         end
         ST_INS_WR: begin
            bm_we    = 1'b1;
            bm_waddr = iaddr_ff;
            bm_wdata = bm_rdata | (64'd1 << count_ff[5:0]);
            state_in = ST_IDLE;
         end
         ST_QRUN: begin
            bm_raddr = bm_base + AW'(iss_ff);
            // issue one word read per cycle
            if (iss_ff != WCW'(WORDS)) begin
               rdv_in = 1'b1;
               rdw_in = iss_ff;
               iss_in = iss_ff + WCW'(1);
            end else if (!rdv_ff) begin
               state_in = cur_ff.last ? ST_QEND : ST_IDLE;
            end
            // combine returned word and track pending hit
            if (rdv_ff) begin
               hw_we = 1'b1;
               if (cur_ff.last && !failed_ff && hit != '0) begin
                  if (pv_ff) begin
                     ov_in = 1'b1;
                     ow_in = bmq_pkg::WIDX_W'(pw_ff);
                     om_in = pm_ff;
                  end
                  pv_in = 1'b1;
                  pw_in = rdw_ff;
                  pm_in = hit;
               end
            end
         end
         ST_QEND: begin
            ov_in     = 1'b1;
            ol_in     = 1'b1;
            if (!failed_ff && pv_ff) begin
               ow_in = bmq_pkg::WIDX_W'(pw_ff);
               om_in = pm_ff;
            end else begin
               oe_in = 1'b1;
            end
            open_in   = 1'b0;
            failed_in = 1'b0;
            pv_in     = 1'b0;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_CLR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLR;
         clr_ff    <= '0;
         count_ff  <= '0;
         open_ff   <= 1'b0;
         failed_ff <= 1'b0;
         rdv_ff    <= 1'b0;
         pv_ff     <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         count_ff  <= count_in;
         open_ff   <= open_in;
         failed_ff <= failed_in;
         rdv_ff    <= rdv_in;
         pv_ff     <= pv_in;
         ov_ff     <= ov_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      first_ff <= first_in;
      iss_ff   <= iss_in;
      rdw_ff   <= rdw_in;
      iaddr_ff <= iaddr_in;
      pw_ff    <= pw_in;
      pm_ff    <= pm_in;
      oe_ff    <= oe_in;
      ol_ff    <= ol_in;
      ow_ff    <= ow_in;
      om_ff    <= om_in;
   end

   assign stat.clearing   = (state_ff == ST_CLR);
   assign rsp_valid       = ov_ff;
   assign rsp_word_index  = ow_ff;
   assign rsp_hit_mask    = om_ff;
   assign rsp_empty_res   = oe_ff;
   assign rsp_last_result = ol_ff;

endmodule

[hw/rtl/bitmap_index_and_query_core.sv]
// top level of the bitmap index and conjunctive query block
`timescale 1ns / 1ps
// Usage: an item (req_kind, req_keyword, req_last) is taken when start is
// high and busy is low. Kinds: clear the index, set a keyword bit of the
// current object, close the object, or a query term. Items go into a
// two-entry queue, so start may follow busy low on any cycle.
// Results appear on rsp_* for exactly one cycle, marked by rsp_valid; the
// receiver cannot stall, so none is held back.
// Steps: a keyword item makes the back end read, modify and write one
// bitmap word (ST_INS_RD, ST_INS_WR); a close item is handled in ST_IDLE;
// a query term reads WORDS words, WORDS = MAX_OBJECTS/64 rounded up (64 at
// the default), through the single read port of the bitmap memory, one
// 64-bit word a cycle. The final term adds a closing state (ST_QEND); its
// results stream out during its pass, the last result from ST_QEND.
// Reset and a clear item both start a clearing pass over all
// MAX_KEYWORDS*WORDS words of the bitmap memory (65536 at default), during
// which busy is high and no item is taken.
module bitmap_index_and_query_core #(
   parameter int MAX_KEYWORDS = bmq_pkg::MAX_KEYWORDS_DEF,
   parameter int MAX_OBJECTS  = bmq_pkg::MAX_OBJECTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_kind,
   input  logic [bmq_pkg::KW_W-1:0]    req_keyword,
   input  logic                        req_last,
   output logic                        rsp_valid,
   output logic [bmq_pkg::WIDX_W-1:0]  rsp_word_index,
   output logic [bmq_pkg::MASK_W-1:0]  rsp_hit_mask,
   output logic                        rsp_empty_res,
   output logic                        rsp_last_result
);

   bmq_pkg::item_type item;
   bmq_pkg::stat_type stat;
   logic              item_valid, item_pop;

   bmq_front #(.MAX_KEYWORDS(MAX_KEYWORDS)) u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_keyword(req_keyword), .req_last(req_last),
      .stat(stat), .item_valid(item_valid), .item(item), .item_pop(item_pop)
   );

   bmq_back #(.MAX_KEYWORDS(MAX_KEYWORDS), .MAX_OBJECTS(MAX_OBJECTS)) u_back (
      .clock(clock), .reset(reset), .item_valid(item_valid), .item(item),
      .item_pop(item_pop), .stat(stat), .rsp_valid(rsp_valid),
      .rsp_word_index(rsp_word_index), .rsp_hit_mask(rsp_hit_mask),
      .rsp_empty_res(rsp_empty_res), .rsp_last_result(rsp_last_result)
   );

   // no result while the store is being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      stat.clearing |-> !rsp_valid) else $error("result during clearing pass");

   // an empty result is alone and final
   a_empty_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last_result && rsp_hit_mask == '0)
      else $error("malformed empty result");

   // a hit result carries at least one object
   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_empty_res |-> rsp_hit_mask != '0)
      else $error("hit result with zero mask");

endmodule

[tb/testbench.sv]
// testbench for the bitmap index and conjunctive query block
`timescale 1ns / 1ps
module testbench;

   localparam int NKW   = bmq_pkg::MAX_KEYWORDS_DEF;
   localparam int NOBJ  = bmq_pkg::MAX_OBJECTS_DEF;
   localparam int NWORD = (NOBJ + 63) / 64;

   typedef struct {
      logic [bmq_pkg::WIDX_W-1:0] word_index;
      logic [bmq_pkg::MASK_W-1:0] hit_mask;
      logic                       empty_res;
      logic                       last_result;
   } hit_type;

   typedef struct {
      bmq_pkg::kind_type          kind;
      logic [bmq_pkg::KW_W-1:0]   keyword;
      logic                       last;
      logic                       typed;
      logic [bmq_pkg::WIDX_W-1:0] word_index;
      logic [bmq_pkg::MASK_W-1:0] hit_mask;
      logic                       empty_res;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_kind = bmq_pkg::KIND_CLEAR;
   logic [bmq_pkg::KW_W-1:0] req_keyword = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic [bmq_pkg::WIDX_W-1:0] rsp_word_index;
   logic [bmq_pkg::MASK_W-1:0] rsp_hit_mask;
   logic rsp_empty_res;
   logic rsp_last_result;

   // predictor state
   logic [bmq_pkg::MASK_W-1:0] kw_bitmap [NKW][NWORD];
   logic [bmq_pkg::MASK_W-1:0] hit_acc [64];
   int unsigned obj_count;
   bit q_open, q_failed;

   hit_type hits_due [$];
   hit_type predicted [$];
   int mismatches;
   bit no_gaps;

   bitmap_index_and_query_core i_dut (.*);

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   initial begin
      #(8 * 3_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [bmq_pkg::MASK_W-1:0] closed_mask(int unsigned w);
      int unsigned base;
      base = w * 64;
      if (obj_count <= base) return '0;
      if (obj_count - base >= 64) return '1;
      return (64'd1 << (obj_count - base)) - 64'd1;
   endfunction

   // computes the hits an item causes and updates the store
   task automatic index_update(bmq_pkg::kind_type k, logic [bmq_pkg::KW_W-1:0] kw,
                               logic l);
      logic [bmq_pkg::MASK_W-1:0] m, v;
      hit_type h;
      predicted.delete();
      case (k)
         bmq_pkg::KIND_CLEAR: begin
            foreach (kw_bitmap[i, j]) kw_bitmap[i][j] = '0;
            obj_count = 0;
            q_open = 0;
            q_failed = 0;
         end
         bmq_pkg::KIND_KEYWORD: begin
            if (obj_count < NOBJ && kw < NKW)
               kw_bitmap[kw][obj_count >> 6][obj_count & 63] = 1'b1;
         end
         bmq_pkg::KIND_CLOSE: begin
            if (obj_count < NOBJ) obj_count++;
         end
         default: begin
            if (kw >= NKW) begin
               if (!q_open) foreach (hit_acc[w]) hit_acc[w] = '0;
               q_failed = 1;
            end else begin
               for (int w = 0; w < 64; w++) begin
                  v = (w < NWORD) ? kw_bitmap[kw][w] : '0;
                  hit_acc[w] = q_open ? (hit_acc[w] & v) : v;
               end
               if (!q_open) q_failed = 0;
            end
            q_open = 1;
            if (l) begin
               if (!q_failed && obj_count != 0)
                  for (int w = 0; w < 64; w++) begin
                     m = hit_acc[w] & closed_mask(w);
                     if (m != 0) begin
                        h.word_index = bmq_pkg::WIDX_W'(w);
                        h.hit_mask = m;
                        h.empty_res = 0;
                        h.last_result = 0;
                        predicted = {predicted, h};
                     end
                  end
               if (predicted.size() == 0) begin
                  h.word_index = '0;
                  h.hit_mask = '0;
                  h.empty_res = 1;
                  h.last_result = 1;
                  predicted = {predicted, h};
               end else begin
                  predicted[predicted.size()-1].last_result = 1;
               end
               q_open = 0;
               q_failed = 0;
            end
         end
      endcase
   endtask

   // hands one item to the block and records its expected hits
   task automatic send_item(bmq_pkg::kind_type k, logic [bmq_pkg::KW_W-1:0] kw,
                            logic l);
      int gap;
      if (!no_gaps && $urandom_range(99) < 35) begin
         start = 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_kind = k;
      req_keyword = kw;
      req_last = l;
      do @(posedge clock); while (busy);
      index_update(k, kw, l);
      hits_due = {hits_due, predicted};
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (hits_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      hit_type e;
      if (!reset && rsp_valid) begin
         if (hits_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp none got %0d %h %b %b",
                  rsp_word_index, rsp_hit_mask, rsp_empty_res, rsp_last_result);
         end else begin
            e = hits_due.pop_front();
            if (rsp_word_index !== e.word_index || rsp_hit_mask !== e.hit_mask ||
                rsp_empty_res !== e.empty_res || rsp_last_result !== e.last_result) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d %h %b %b got %0d %h %b %b",
                     e.word_index, e.hit_mask, e.empty_res, e.last_result,
                     rsp_word_index, rsp_hit_mask, rsp_empty_res, rsp_last_result);
            end
         end
      end
   end

   // directed rows, expectations typed where obvious
   row_type rows [] = '{
      '{bmq_pkg::KIND_QUERY,   10'd0,    1'b1, 1'b1, 6'd0, 64'd0, 1'b1},
      '{bmq_pkg::KIND_KEYWORD, 10'd1023, 1'b0, 1'b0, 6'd0, 64'd0, 1'b0},
      '{bmq_pkg::KIND_CLOSE,   10'd0,    1'b0, 1'b0, 6'd0, 64'd0, 1'b0},
      '{bmq_pkg::KIND_QUERY,   10'd1023, 1'b1, 1'b1, 6'd0, 64'd1, 1'b0},
      '{bmq_pkg::KIND_KEYWORD, 10'd0,    1'b0, 1'b0, 6'd0, 64'd0, 1'b0},
      '{bmq_pkg::KIND_QUERY,   10'd0,    1'b1, 1'b1, 6'd0, 64'd0, 1'b1},
      '{bmq_pkg::KIND_CLOSE,   10'd0,    1'b0, 1'b0, 6'd0, 64'd0, 1'b0},
      '{bmq_pkg::KIND_QUERY,   10'd0,    1'b0, 1'b0, 6'd0, 64'd0, 1'b0},
      '{bmq_pkg::KIND_QUERY,   10'd1023, 1'b1, 1'b1, 6'd0, 64'd0, 1'b1},
      '{bmq_pkg::KIND_KEYWORD, 10'd5,    1'b0, 1'b0, 6'd0, 64'd0, 1'b0},
      '{bmq_pkg::KIND_KEYWORD, 10'd5,    1'b0, 1'b0, 6'd0, 64'd0, 1'b0},
      '{bmq_pkg::KIND_CLOSE,   10'd0,    1'b0, 1'b0, 6'd0, 64'd0, 1'b0},
      '{bmq_pkg::KIND_QUERY,   10'd5,    1'b1, 1'b1, 6'd0, 64'd4, 1'b0},
      '{bmq_pkg::KIND_QUERY,   10'd7,    1'b1, 1'b1, 6'd0, 64'd0, 1'b1},
      '{bmq_pkg::KIND_QUERY,   10'd5,    1'b0, 1'b0, 6'd0, 64'd0, 1'b0},
      '{bmq_pkg::KIND_KEYWORD, 10'd5,    1'b0, 1'b0, 6'd0, 64'd0, 1'b0},
      '{bmq_pkg::KIND_CLOSE,   10'd0,    1'b0, 1'b0, 6'd0, 64'd0, 1'b0},
      '{bmq_pkg::KIND_QUERY,   10'd5,    1'b1, 1'b1, 6'd0, 64'd4, 1'b0},
      '{bmq_pkg::KIND_QUERY,   10'd682,  1'b1, 1'b0, 6'd0, 64'd0, 1'b0},
      '{bmq_pkg::KIND_CLEAR,   10'd0,    1'b0, 1'b0, 6'd0, 64'd0, 1'b0},
      '{bmq_pkg::KIND_QUERY,   10'd5,    1'b1, 1'b1, 6'd0, 64'd0, 1'b1}
   };

   function automatic logic [bmq_pkg::KW_W-1:0] pick_keyword();
      if ($urandom_range(99) < 80) return bmq_pkg::KW_W'($urandom_range(0, 7));
      return bmq_pkg::KW_W'($urandom_range(0, NKW - 1));
   endfunction

   // stimulus
   initial begin
      hit_type h;
      // predictor starts from a cleared store
      index_update(bmq_pkg::KIND_CLEAR, '0, 1'b0);
      foreach (hit_acc[w]) hit_acc[w] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part
      foreach (rows[r]) begin
         send_item(rows[r].kind, rows[r].keyword, rows[r].last);
         if (rows[r].typed) begin
            repeat (predicted.size()) void'(hits_due.pop_back());
            h.word_index = rows[r].word_index;
            h.hit_mask = rows[r].hit_mask;
            h.empty_res = rows[r].empty_res;
            h.last_result = 1;
            hits_due = {hits_due, h};
         end
      end
      wait_drained();

      // build objects past one full word, then query across words
      for (int i = 0; i < 70; i++) begin
         no_gaps = (i < 30);
         if ($urandom_range(1)) send_item(bmq_pkg::KIND_KEYWORD, pick_keyword(), 1'b0);
         if (i % 97 == 0) send_item(bmq_pkg::KIND_KEYWORD, 10'd1023, 1'b0);
         send_item(bmq_pkg::KIND_CLOSE, 10'd0, 1'b0);
      end
      no_gaps = 0;
      send_item(bmq_pkg::KIND_KEYWORD, 10'd3, 1'b0);
      for (int i = 0; i < 12; i++)
         send_item(bmq_pkg::KIND_QUERY, pick_keyword(), i % 3 == 2);
      send_item(bmq_pkg::KIND_QUERY, 10'd1023, 1'b1);
      send_item(bmq_pkg::KIND_CLEAR, 10'd0, 1'b0);

      // random part
      for (int i = 0; i < 300; i++) begin
         int sel;
         no_gaps = (i >= 100 && i < 170);
         if (i == 220) wait_drained();
         sel = $urandom_range(99);
         if (i == 150 || i == 260)
            send_item(bmq_pkg::KIND_CLEAR, pick_keyword(), 1'($urandom_range(1)));
         else if (sel < 40)
            send_item(bmq_pkg::KIND_KEYWORD, pick_keyword(), 1'($urandom_range(1)));
         else if (sel < 65)
            send_item(bmq_pkg::KIND_CLOSE, pick_keyword(), 1'($urandom_range(1)));
         else
            send_item(bmq_pkg::KIND_QUERY, pick_keyword(), $urandom_range(99) < 45);
      end
      send_item(bmq_pkg::KIND_QUERY, pick_keyword(), 1'b1);
      start = 1'b0;

      while (hits_due.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
